### rtl/core/rle_palette_pixel_expander_macros.svh
// assertion macros used by the expander back end
`ifndef RLE_PALETTE_PIXEL_EXPANDER_MACROS_SVH
`define RLE_PALETTE_PIXEL_EXPANDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RPE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpe same-cycle check failed");

// next-cycle implication, checked outside reset
`define RPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpe next-cycle check failed");

`endif

### rtl/core/rpe_pkg.sv
// shared types and constants of the run-length palette expander
package rpe_pkg;

    localparam int PIX_W   = 16;
    localparam int LEN_W   = 8;
    localparam int IDX_W8  = 8;
    localparam int CNT_W   = 3;
    localparam int LEFT_W  = 9;
    localparam int GROUP   = 4;

    localparam logic REQ_RUN   = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // one run ready for expansion: looked-up color and length minus one
    typedef struct packed {
        logic [PIX_W-1:0] color;
        logic [LEN_W-1:0] len_m1;
    } t_job;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/core/rpe_if.sv
// stream interfaces for input requests and output pixel groups
interface rpe_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] run_word;
    logic [7:0]  entry_index;
    logic [15:0] entry_color;

    modport source (output valid, output req_type, output run_word,
                    output entry_index, output entry_color, input ready);
    modport sink   (input valid, input req_type, input run_word,
                    input entry_index, input entry_color, output ready);
endinterface

interface rpe_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_a;
    logic [15:0] pixel_b;
    logic [15:0] pixel_c;
    logic [15:0] pixel_d;
    logic [2:0]  valid_count;
    logic        run_last;

    modport source (output valid, output pixel_a, output pixel_b, output pixel_c,
                    output pixel_d, output valid_count, output run_last, input ready);
    modport sink   (input valid, input pixel_a, input pixel_b, input pixel_c,
                    input pixel_d, input valid_count, input run_last, output ready);
endinterface

### rtl/core/rpe_front.sv
// request intake: palette writes and registered palette lookup for runs
module rpe_front
    import rpe_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpe_in_if.sink     i_in,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_job       o_job
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [PIX_W-1:0] r_pal [PALETTE_ENTRIES];

    logic             r_lk_valid;
    logic             n_lk_valid;
    logic [PIX_W-1:0] r_rd_color;
    logic             r_oob;
    logic [LEN_W-1:0] r_len_m1;

    logic accept;
    logic acc_run;
    logic acc_write;
    logic wr_in_range;
    logic rd_in_range;

    assign i_in.ready = !r_lk_valid || !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign acc_run    = accept && (i_in.req_type == REQ_RUN);
    assign acc_write  = accept && (i_in.req_type == REQ_WRITE);

    assign wr_in_range = {1'b0, i_in.entry_index} < 9'(PALETTE_ENTRIES);
    assign rd_in_range = {1'b0, i_in.run_word[IDX_W8-1:0]} < 9'(PALETTE_ENTRIES);

    assign o_push = r_lk_valid && !i_q_status.full;
    assign o_job  = '{color: (r_oob ? '0 : r_rd_color), len_m1: r_len_m1};

    always_comb begin
        n_lk_valid = r_lk_valid;
        if (o_push) begin
            n_lk_valid = 1'b0;
        end
        if (acc_run) begin
            n_lk_valid = 1'b1;
        end
    end

    // palette store, written and read in the clock
    always_ff @(posedge i_clk) begin
        if (acc_write && wr_in_range) begin
            r_pal[i_in.entry_index[IDX_W-1:0]] <= i_in.entry_color;
        end
        if (acc_run) begin
            r_rd_color <= r_pal[i_in.run_word[IDX_W-1:0]];
            r_oob      <= !rd_in_range;
            r_len_m1   <= i_in.run_word[LEN_W+IDX_W8-1:IDX_W8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lk_valid <= 1'b0;
        end else begin
            r_lk_valid <= n_lk_valid;
        end
    end

endmodule

### rtl/core/rpe_queue.sv
// short job queue between lookup and expansion
module rpe_queue
    import rpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_job       i_job,
    input  logic       i_pop,
    output t_job       o_job,
    output t_q_status  o_status
);

    t_job               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;

    assign o_job           = r_slot[r_rd];
    assign o_status.full   = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty  = (r_cnt == '0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + Q_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/core/rpe_back.sv
// run expansion into groups of up to four pixels with registered output
`include "rle_palette_pixel_expander_macros.svh"

module rpe_back
    import rpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    rpe_out_if.source  o_out
);

    logic              r_busy;
    logic              n_busy;
    logic [LEFT_W-1:0] r_left;
    logic [LEFT_W-1:0] n_left;
    logic [PIX_W-1:0]  r_color;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [PIX_W-1:0]  r_pix [GROUP];
    logic [CNT_W-1:0]  r_cnt;
    logic              r_last;

    logic              emit;
    logic [CNT_W-1:0]  grp_cnt;
    logic [LEFT_W-1:0] grp_cnt_w;

    assign o_pop     = !r_busy && !i_q_status.empty;
    assign emit      = r_busy && (!r_out_valid || o_out.ready);
    assign grp_cnt   = (r_left > LEFT_W'(GROUP)) ? CNT_W'(GROUP) : r_left[CNT_W-1:0];
    assign grp_cnt_w = LEFT_W'(grp_cnt);

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_a     = r_pix[0];
    assign o_out.pixel_b     = r_pix[1];
    assign o_out.pixel_c     = r_pix[2];
    assign o_out.pixel_d     = r_pix[3];
    assign o_out.valid_count = r_cnt;
    assign o_out.run_last    = r_last;

    always_comb begin
        n_busy      = r_busy;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (emit) begin
            n_out_valid = 1'b1;
            n_left      = r_left - grp_cnt_w;
            n_busy      = (r_left != grp_cnt_w);
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_left = LEFT_W'(i_job.len_m1) + LEFT_W'(1);
        end
    end

    // output payload, unused slots zero
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_color <= i_job.color;
        end
        if (emit) begin
            for (int j = 0; j < GROUP; j++) begin
                r_pix[j] <= (CNT_W'(j) < grp_cnt) ? r_color : '0;
            end
            r_cnt  <= grp_cnt;
            r_last <= (r_left == grp_cnt_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    `RPE_ASSERT_NOW(a_busy_has_pixels, r_busy, r_left != '0)
    `RPE_ASSERT_NOW(a_short_group_is_last, r_out_valid && !r_last, r_cnt == CNT_W'(GROUP))
    `RPE_ASSERT_NEXT(a_pop_starts_run, o_pop, r_busy && r_left != '0)

endmodule

### rtl/core/rle_palette_pixel_expander.sv
// top level of the run-length palette pixel expander
// a run word reaches the output through the lookup register, the job queue, the expander and the output register
// the expander counter gives one group per cycle while the receiver takes them; a run of n
//   pixels gives ceil(n/4) groups, up to 64, and the next job loads only once the run is done
// palette writes and run words share the input, which stalls only while a looked-up job waits on a full job queue
// reset clears the queue, lookup stage and expander; the palette store holds no reset value
module rle_palette_pixel_expander
    import rpe_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpe_in_if.sink     i_in,
    rpe_out_if.source  o_out
);

    // front side: palette writes land at once, run words read the palette
    // in the same cycle they are accepted, so a write is seen by any later run
    t_job      front_job;
    logic      front_push;

    // queue between lookup and expansion
    t_job      q_job;
    t_q_status q_status;
    logic      back_pop;

    rpe_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (front_push),
        .o_job      (front_job)
    );

    // two-entry queue lets intake keep going while a long run expands
    rpe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_job    (front_job),
        .i_pop    (back_pop),
        .o_job    (q_job),
        .o_status (q_status)
    );

    // back side: counts down the run, up to four pixels per transaction,
    // output register parts it from the downstream stall
    rpe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_job),
        .i_q_status (q_status),
        .o_pop      (back_pop),
        .o_out      (o_out)
    );

endmodule

### tb/rle_palette_pixel_expander_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the run-length palette pixel expander
module rle_palette_pixel_expander_test
    import rpe_pkg::*;
();

    localparam int PAL_ENTRIES  = 256;
    localparam int RAND_ITEMS   = 110;
    localparam int HOLD_CYCLES  = 300;      // long receiver hold-off, fills the job queue
    localparam int HOLD_AFTER   = 20;       // groups seen before the hold-off starts
    localparam int DRAIN_CYCLES = 8;        // idle tail after the expected groups drain, to catch strays
    localparam int GAP_PCT      = 33;
    localparam longint LIMIT_NS = 64'd10_000_000;

    // one input transaction as seen on the request channel
    typedef struct packed {
        logic        req_type;
        logic [15:0] run_word;
        logic [7:0]  entry_index;
        logic [15:0] entry_color;
    } t_pix_req;

    // one output transaction: a group of up to four pixels
    typedef struct packed {
        logic [15:0] pixel_a;
        logic [15:0] pixel_b;
        logic [15:0] pixel_c;
        logic [15:0] pixel_d;
        logic [2:0]  valid_count;
        logic        run_last;
    } t_pix_group;

    // directed stimulus row, with a typed-in group for single-group runs
    typedef struct {
        t_pix_req   req;
        bit         typed;
        t_pix_group grp;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    rpe_in_if  in_if ();
    rpe_out_if out_if ();

    // sideband that travels with a directed row: use the typed-in group
    bit         drv_typed;
    t_pix_group drv_typed_grp;

    // predictor state: palette image and the groups still to come
    logic [15:0] palette_img [PAL_ENTRIES];
    t_pix_group  pending_groups [$];

    // sender bookkeeping: palette entries already loaded, safe to read
    bit          loaded_mask [256];
    logic [7:0]  loaded_idx [$];
    t_dir_row    dir_rows [$];

    bit steady;          // both sides stop idling while set
    int n_errors;
    int n_runs;
    int n_writes;
    int n_groups;
    int longest_run;

    rle_palette_pixel_expander #(
        .PALETTE_ENTRIES(PAL_ENTRIES)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog on the whole run
    initial begin
        #(LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // predictor: palette writes load the image, run words expand into groups
    task automatic predict_request(input t_pix_req r);
        int          left;
        int          cnt;
        logic [15:0] color;
        t_pix_group  g;
        if (r.req_type == REQ_WRITE) begin
            // writes beyond the palette size are dropped
            if (int'(r.entry_index) < PAL_ENTRIES)
                palette_img[r.entry_index] = r.entry_color;
        end else begin
            left  = int'(r.run_word[15:8]) + 1;
            // an index beyond the palette reads color zero
            color = (int'(r.run_word[7:0]) < PAL_ENTRIES) ? palette_img[r.run_word[7:0]] : '0;
            while (left > 0) begin
                cnt           = (left > 4) ? 4 : left;
                // slots past the valid count stay zero
                g.pixel_a     = color;
                g.pixel_b     = (cnt >= 2) ? color : 16'h0000;
                g.pixel_c     = (cnt >= 3) ? color : 16'h0000;
                g.pixel_d     = (cnt >= 4) ? color : 16'h0000;
                g.valid_count = cnt[2:0];
                left          = left - cnt;
                g.run_last    = (left == 0);
                pending_groups.push_back(g);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    // input acceptance feeds the predictor, output acceptance is checked,
    // both sampled at the same edge so ordering is fixed
    always @(posedge i_clk) begin
        t_pix_req   acc;
        t_pix_group got;
        t_pix_group want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                acc = {in_if.req_type, in_if.run_word, in_if.entry_index, in_if.entry_color};
                if (acc.req_type == REQ_WRITE)
                    n_writes++;
                else
                    n_runs++;
                // typed rows are single-group runs, they leave the palette alone
                if (acc.req_type == REQ_RUN && drv_typed)
                    pending_groups.push_back(drv_typed_grp);
                else
                    predict_request(acc);
            end
            if (out_if.valid && out_if.ready) begin
                got = {out_if.pixel_a, out_if.pixel_b, out_if.pixel_c, out_if.pixel_d,
                       out_if.valid_count, out_if.run_last};
                n_groups++;
                if (pending_groups.size() == 0) begin
                    $error("pixel group with nothing expected: 0x%0h", got);
                    n_errors++;
                end else begin
                    want = pending_groups.pop_front();
                    check_field("pixel_a", want.pixel_a, got.pixel_a);
                    check_field("pixel_b", want.pixel_b, got.pixel_b);
                    check_field("pixel_c", want.pixel_c, got.pixel_c);
                    check_field("pixel_d", want.pixel_d, got.pixel_d);
                    check_field("valid_count", 16'(want.valid_count), 16'(got.valid_count));
                    check_field("run_last", 16'(want.run_last), 16'(got.run_last));
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off counted here
    initial begin
        bit held;
        held = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && n_groups >= HOLD_AFTER) begin
                held = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_if.ready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
        end
    end

    task automatic note_loaded(input logic [7:0] idx);
        if (!loaded_mask[idx]) begin
            loaded_mask[idx] = 1'b1;
            loaded_idx.push_back(idx);
        end
    endtask

    // offer one transaction, with a random idle gap ahead of it
    task automatic send_req(input t_pix_req r, input bit typed, input t_pix_group tg);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(0, 99) < GAP_PCT) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.req_type    <= r.req_type;
        in_if.run_word    <= r.run_word;
        in_if.entry_index <= r.entry_index;
        in_if.entry_color <= r.entry_color;
        drv_typed         <= typed;
        drv_typed_grp     <= tg;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (r.req_type == REQ_WRITE)
            note_loaded(r.entry_index);
        else if (int'(r.run_word[15:8]) + 1 > longest_run)
            longest_run = int'(r.run_word[15:8]) + 1;
    endtask

    task automatic dir_write(input logic [7:0] idx, input logic [15:0] col,
                             input logic [15:0] word);
        t_dir_row row;
        row.req   = {REQ_WRITE, word, idx, col};
        row.typed = 1'b0;
        row.grp   = '0;
        dir_rows.push_back(row);
    endtask

    // untyped rows pass typed = 0 and zero pixels, the predictor covers them
    task automatic dir_run(input logic [15:0] word, input logic [7:0] idx,
                           input logic [15:0] col, input bit typed,
                           input logic [15:0] pa, input logic [15:0] pb,
                           input logic [15:0] pc, input logic [15:0] pd,
                           input logic [2:0] cnt);
        t_dir_row row;
        row.req   = {REQ_RUN, word, idx, col};
        row.typed = typed;
        row.grp   = {pa, pb, pc, pd, cnt, 1'b1};
        dir_rows.push_back(row);
    endtask

    // stimulus and end of run
    initial begin
        t_pix_req   r;
        t_pix_group none;
        int         sel;
        none        = '0;
        steady      = 1'b0;
        n_errors    = 0;
        n_runs      = 0;
        n_writes    = 0;
        n_groups    = 0;
        longest_run = 0;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.req_type    <= REQ_RUN;
        in_if.run_word    <= '0;
        in_if.entry_index <= '0;
        in_if.entry_color <= '0;
        drv_typed         <= 1'b0;
        drv_typed_grp     <= '0;

        // palette loads first: extremes, alternating bits, pure primaries;
        // the ignored run word carries junk
        dir_write(8'h00, 16'h0000, 16'hFFFF);
        dir_write(8'hFF, 16'hFFFF, 16'h0000);
        dir_write(8'h55, 16'hA5A5, 16'h1234);
        dir_write(8'hAA, 16'h5A5A, 16'hEDCB);
        dir_write(8'h01, 16'hF800, 16'h00FF);
        dir_write(8'h02, 16'h07E0, 16'hFF00);
        dir_write(8'h03, 16'h001F, 16'hAAAA);
        // single-group runs of 1..4 pixels, unused slots zero
        dir_run(16'h0000, 8'hFF, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd1);
        dir_run(16'h00FF, 8'h00, 16'h0000, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 3'd1);
        dir_run(16'h0155, 8'h12, 16'h3456, 1'b1, 16'hA5A5, 16'hA5A5, 16'h0000, 16'h0000, 3'd2);
        dir_run(16'h02AA, 8'h34, 16'h789A, 1'b1, 16'h5A5A, 16'h5A5A, 16'h5A5A, 16'h0000, 3'd3);
        dir_run(16'h0301, 8'h56, 16'hBCDE, 1'b1, 16'hF800, 16'hF800, 16'hF800, 16'hF800, 3'd4);
        // multi-group runs, longest ones back to back to fill the queue
        dir_run(16'h0402, 8'h00, 16'h0000, 1'b0, '0, '0, '0, '0, '0);
        dir_run(16'hFFFF, 8'h00, 16'h0000, 1'b0, '0, '0, '0, '0, '0);
        dir_run(16'hFF00, 8'h00, 16'h0000, 1'b0, '0, '0, '0, '0, '0);
        // overwrite of a loaded entry is seen by the next run
        dir_write(8'hFF, 16'h1234, 16'hFFFF);
        dir_run(16'h00FF, 8'h00, 16'h0000, 1'b1, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 3'd1);
        dir_run(16'h0703, 8'h00, 16'h0000, 1'b0, '0, '0, '0, '0, '0);
        // entry fields on a run word are ignored
        dir_write(8'h04, 16'hBEEF, 16'hFFFF);
        dir_run(16'h0004, 8'hFF, 16'h0000, 1'b1, 16'hBEEF, 16'h0000, 16'h0000, 16'h0000, 3'd1);
        dir_run(16'h0B04, 8'hAA, 16'hFFFF, 1'b0, '0, '0, '0, '0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].grp);

        // random part: mostly runs over loaded entries, some palette updates
        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 40 && n < 75);
            if ($urandom_range(0, 99) < 30) begin
                r.req_type    = REQ_WRITE;
                r.entry_index = 8'($urandom_range(0, 255));
                r.entry_color = 16'($urandom);
                r.run_word    = 16'($urandom);
            end else begin
                r.req_type    = REQ_RUN;
                sel           = $urandom_range(0, 99);
                // short runs dominate, a few long and a few of full length
                if (sel < 80)
                    r.run_word[15:8] = 8'($urandom_range(0, 15));
                else if (sel < 95)
                    r.run_word[15:8] = 8'($urandom_range(16, 254));
                else
                    r.run_word[15:8] = 8'hFF;
                // only loaded entries are read
                r.run_word[7:0] = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
                r.entry_index   = 8'($urandom);
                r.entry_color   = 16'($urandom);
            end
            send_req(r, 1'b0, none);
        end
        steady = 1'b0;
        in_if.valid <= 1'b0;

        // drain every expected group, then a short tail for strays
        while (pending_groups.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d run words in %0d pixel groups and %0d palette writes",
                 n_runs, n_groups, n_writes);
        $display("longest run %0d pixels, %0d palette entries loaded, one %0d-cycle output hold",
                 longest_run, loaded_idx.size(), HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rpe_pkg.sv
rtl/core/rpe_if.sv
rtl/core/rpe_front.sv
rtl/core/rpe_queue.sv
rtl/core/rpe_back.sv
rtl/core/rle_palette_pixel_expander.sv
tb/rle_palette_pixel_expander_test.sv
